// ----- src/ihfm_pkg.sv -----
// Shared types, register map and helpers for the IR helicopter frame modulator.
`timescale 1ns / 1ps
package ihfm_pkg;

   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned DUR_W      = 18;
   localparam int unsigned WORD_W     = 32;

   // register reset values
   localparam logic [7:0]  CARRIER_HALF_RST = 8'd13;
   localparam logic [7:0]  HDR_MARK_RST     = 8'd76;
   localparam logic [15:0] HDR_SPACE_RST    = 16'd2000;
   localparam logic [7:0]  BIT_MARK_RST     = 8'd11;
   localparam logic [15:0] ONE_SPACE_RST    = 16'd688;
   localparam logic [15:0] ZERO_SPACE_RST   = 16'd288;
   localparam logic [17:0] GAP_RST          = 18'd60000;

   typedef enum logic [2:0] {
      REG_CARRIER_HALF = 3'd0,
      REG_HDR_MARK     = 3'd1,
      REG_HDR_SPACE    = 3'd2,
      REG_BIT_MARK     = 3'd3,
      REG_ONE_SPACE    = 3'd4,
      REG_ZERO_SPACE   = 3'd5,
      REG_GAP          = 3'd6
   } reg_idx_type;

   typedef struct packed {
      logic [7:0]  carrier_half;
      logic [7:0]  hdr_mark;
      logic [15:0] hdr_space;
      logic [7:0]  bit_mark;
      logic [15:0] one_space;
      logic [15:0] zero_space;
      logic [17:0] gap;
   } cfg_type;

   typedef enum logic [6:0] {
      PH_IDLE       = 7'b0000001,
      PH_HDR_MARK   = 7'b0000010,
      PH_HDR_SPACE  = 7'b0000100,
      PH_BIT_MARK   = 7'b0001000,
      PH_BIT_SPACE  = 7'b0010000,
      PH_CLOSE_MARK = 7'b0100000,
      PH_GAP        = 7'b1000000
   } phase_type;

   // classified tick: start flag plus the packed frame word
   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] word;
   } tick_type;

   typedef struct packed {
      logic     valid;
      tick_type item;
   } qh_type;

   // a zero length acts as one
   function automatic logic [7:0] nz8(input logic [7:0] v);
      return (v == 8'd0) ? 8'd1 : v;
   endfunction

   function automatic logic [15:0] nz16(input logic [15:0] v);
      return (v == 16'd0) ? 16'd1 : v;
   endfunction

endpackage

// ----- src/ihfm_ifs.sv -----
// Request and response channel interfaces of the frame modulator.
`timescale 1ns / 1ps
interface ihfm_req_if;
   logic       valid;
   logic       ready;
   logic       start_req;
   logic [7:0] yaw_byte;
   logic [7:0] pitch_byte;
   logic [7:0] throttle_byte;
   logic [7:0] trim_byte;

   modport source(output valid, start_req, yaw_byte, pitch_byte, throttle_byte, trim_byte,
                  input ready);
   modport sink(input valid, start_req, yaw_byte, pitch_byte, throttle_byte, trim_byte,
                output ready);
endinterface

interface ihfm_rsp_if;
   logic valid;
   logic ready;
   logic led_on;
   logic busy_res;
   logic frame_done;

   modport source(output valid, led_on, busy_res, frame_done, input ready);
   modport sink(input valid, led_on, busy_res, frame_done, output ready);
endinterface

// ----- src/ihfm_csr.sv -----
// APB-style register file holding the waveform timing registers.
`timescale 1ns / 1ps
module ihfm_csr
   import ihfm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type     cfg_ff, cfg_in;
   reg_idx_type idx;
   logic        wr_en;

   assign idx    = reg_idx_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_CARRIER_HALF: cfg_in.carrier_half = pwdata[7:0];
            REG_HDR_MARK:     cfg_in.hdr_mark     = pwdata[7:0];
            REG_HDR_SPACE:    cfg_in.hdr_space    = pwdata[15:0];
            REG_BIT_MARK:     cfg_in.bit_mark     = pwdata[7:0];
            REG_ONE_SPACE:    cfg_in.one_space    = pwdata[15:0];
            REG_ZERO_SPACE:   cfg_in.zero_space   = pwdata[15:0];
            REG_GAP:          cfg_in.gap          = pwdata[17:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_CARRIER_HALF: prdata = CSR_DATA_W'(cfg_ff.carrier_half);
         REG_HDR_MARK:     prdata = CSR_DATA_W'(cfg_ff.hdr_mark);
         REG_HDR_SPACE:    prdata = CSR_DATA_W'(cfg_ff.hdr_space);
         REG_BIT_MARK:     prdata = CSR_DATA_W'(cfg_ff.bit_mark);
         REG_ONE_SPACE:    prdata = CSR_DATA_W'(cfg_ff.one_space);
         REG_ZERO_SPACE:   prdata = CSR_DATA_W'(cfg_ff.zero_space);
         REG_GAP:          prdata = CSR_DATA_W'(cfg_ff.gap);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.carrier_half <= CARRIER_HALF_RST;
         cfg_ff.hdr_mark     <= HDR_MARK_RST;
         cfg_ff.hdr_space    <= HDR_SPACE_RST;
         cfg_ff.bit_mark     <= BIT_MARK_RST;
         cfg_ff.one_space    <= ONE_SPACE_RST;
         cfg_ff.zero_space   <= ZERO_SPACE_RST;
         cfg_ff.gap          <= GAP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- src/ihfm_front.sv -----
// Front end: takes tick transactions, packs the frame word, queues two deep.
`timescale 1ns / 1ps
module ihfm_front
   import ihfm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   ihfm_req_if.sink   req,
   output qh_type     q,
   input  logic       q_ready
);

   tick_type   entry_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       push, pop;
   tick_type   tick;

   // bytes go out yaw first, MSB first
   assign tick.start = req.start_req;
   assign tick.word  = {req.yaw_byte, req.pitch_byte, req.throttle_byte, req.trim_byte};

   assign req.ready = !count_ff[1];
   assign push      = req.valid && req.ready;
   assign q.valid   = (count_ff != 2'd0);
   assign q.item    = entry_ff[rd_ptr_ff];
   assign pop       = q.valid && q_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= tick;
      end
   end

endmodule

// ----- src/ihfm_engine.sv -----
// Back end: one waveform tick per popped transaction, registered result.
`timescale 1ns / 1ps
module ihfm_engine
   import ihfm_pkg::*;
#(
   parameter int unsigned FRAME_BYTES = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  qh_type      q,
   output logic        q_ready,
   ihfm_rsp_if.source  rsp
);

   localparam int unsigned FRAME_BITS = FRAME_BYTES * 8;
   localparam int unsigned BIT_W      = $clog2(FRAME_BITS);
   localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(FRAME_BITS - 1);

   phase_type         phase_ff, phase_in, ph;
   logic [WORD_W-1:0] shift_ff, shift_in, sh;
   logic [BIT_W-1:0]  bits_ff, bits_in, bl;
   logic [DUR_W-1:0]  dur_ff, dur_in, du, dur_dec, half_len;
   logic [7:0]        cc_ff, cc_in, cc, cc_dec;
   logic              level_ff, level_in, lv;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              led_ff, led_in, busy_ff, busy_in, done_ff, done_in;
   logic              mark_done, pop;

   assign q_ready  = !rsp_valid_ff || rsp.ready;
   assign pop      = q.valid && q_ready;
   assign half_len = DUR_W'(nz8(cfg.carrier_half));

   // a start on an idle tick loads the frame and opens the header mark
   always_comb begin
      ph = phase_ff;
      sh = shift_ff;
      bl = bits_ff;
      du = dur_ff;
      cc = cc_ff;
      lv = level_ff;
      if ((phase_ff == PH_IDLE) && q.item.start) begin
         ph = PH_HDR_MARK;
         sh = q.item.word;
         bl = LAST_BIT;
         cc = nz8(cfg.hdr_mark);
         lv = 1'b1;
         du = half_len;
      end
   end

   always_comb begin
      phase_in  = ph;
      shift_in  = sh;
      bits_in   = bl;
      cc_in     = cc;
      level_in  = lv;
      dur_dec   = du - DUR_W'(1);
      cc_dec    = cc - 8'd1;
      dur_in    = dur_dec;
      mark_done = 1'b0;
      led_in    = 1'b0;
      busy_in   = 1'b1;
      done_in   = 1'b0;
      unique case (ph) inside
         PH_HDR_MARK, PH_BIT_MARK, PH_CLOSE_MARK: begin
            led_in = lv;
            if (dur_dec == '0) begin
               if (lv) begin
                  level_in = 1'b0;
                  dur_in   = half_len;
               end else begin
                  cc_in = cc_dec;
                  if (cc_dec == 8'd0) begin
                     mark_done = 1'b1;
                  end else begin
                     level_in = 1'b1;
                     dur_in   = half_len;
                  end
               end
            end
            if (mark_done) begin
               if (ph == PH_HDR_MARK) begin
                  phase_in = PH_HDR_SPACE;
                  dur_in   = DUR_W'(nz16(cfg.hdr_space));
               end else if (ph == PH_BIT_MARK) begin
                  phase_in = PH_BIT_SPACE;
                  dur_in   = DUR_W'(nz16(sh[WORD_W-1] ? cfg.one_space : cfg.zero_space));
               end else if (cfg.gap == '0) begin
                  done_in  = 1'b1;
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_GAP;
                  dur_in   = cfg.gap;
               end
            end
         end
         PH_HDR_SPACE, PH_BIT_SPACE, PH_GAP: begin
            if (dur_dec == '0) begin
               if (ph == PH_GAP) begin
                  done_in  = 1'b1;
                  phase_in = PH_IDLE;
               end else begin
                  if ((ph == PH_BIT_SPACE) && (bl == '0)) begin
                     phase_in = PH_CLOSE_MARK;
                  end else begin
                     if (ph == PH_BIT_SPACE) begin
                        shift_in = {sh[WORD_W-2:0], 1'b0};
                        bits_in  = bl - BIT_W'(1);
                     end
                     phase_in = PH_BIT_MARK;
                  end
                  cc_in    = nz8(cfg.bit_mark);
                  level_in = 1'b1;
                  dur_in   = half_len;
               end
            end
         end
         default: begin
            // idle, nothing moves
            phase_in = PH_IDLE;
            dur_in   = du;
            busy_in  = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = pop || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         shift_ff     <= '0;
         bits_ff      <= '0;
         dur_ff       <= '0;
         cc_ff        <= '0;
         level_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            phase_ff <= phase_in;
            shift_ff <= shift_in;
            bits_ff  <= bits_in;
            dur_ff   <= dur_in;
            cc_ff    <= cc_in;
            level_ff <= level_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         led_ff  <= led_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.led_on     = led_ff;
   assign rsp.busy_res   = busy_ff;
   assign rsp.frame_done = done_ff;

endmodule

// ----- src/ir_helicopter_frame_modulator.sv -----
// Top level of the IR helicopter frame modulator: registers, front end, tick engine.
`timescale 1ns / 1ps
// Path: an accepted tick transaction is written into the front queue, then popped into
//   the result register that drives rsp; a stalled rsp holds it in the queue.
// Throughput: one tick per cycle while rsp takes results; a stalled rsp stops the pops.
// Reset: synchronous, active high; phase goes idle, queue and result empty,
//   timing registers return to their defaults. No clearing pass.
module ir_helicopter_frame_modulator
   import ihfm_pkg::*;
#(
   parameter int unsigned FRAME_BYTES = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   ihfm_req_if.sink              req,
   ihfm_rsp_if.source            rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type cfg;
   qh_type  q_hs;   // front -> engine queue head
   logic    q_ready;

   // timing registers, sampled by the engine whenever an interval opens
   ihfm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // front: accepts tick transactions, packs the four bytes, 2-deep queue
   ihfm_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .q       (q_hs),
      .q_ready (q_ready)
   );

   // back: frame sequencer and carrier generator, one tick per pop,
   // result held in an output register so the queue keeps flowing
   ihfm_engine #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q       (q_hs),
      .q_ready (q_ready),
      .rsp     (rsp)
   );

`ifndef ASSERT_OFF
   // frame end only ever reported inside a frame
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.frame_done) |-> rsp.busy_res)
      else $error("frame_done outside a frame");

   // LED dark while idle
   a_idle_dark: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.busy_res) |-> !rsp.led_on)
      else $error("LED driven while idle");

   // every queue pop lands in the result register
   a_pop_result: assert property (@(posedge clock) disable iff (reset)
      (q_hs.valid && q_ready) |=> rsp.valid)
      else $error("popped tick produced no result");
`endif

endmodule

// ----- test/ir_helicopter_frame_modulator_tb.sv -----
// Self-checking testbench for the IR helicopter frame modulator tick engine.
`timescale 1ns / 1ps
module ir_helicopter_frame_modulator_tb;
   import ihfm_pkg::*;

   localparam int unsigned FRAME_BYTES = 4;
   localparam int unsigned DRAIN_CYCLES = 6;     // pipeline is two deep, keep some margin
   localparam int unsigned HOLD_CYCLES = 80;     // long rsp hold-off, fills the block up
   localparam int unsigned HOLD_AFTER = 400;     // results seen before the long hold-off

   // Expected LED sample of one tick transaction
   typedef struct packed {
      logic led;
      logic busy;
      logic done;
   } led_sample_type;

   // ----------------------------------------------------------------------
   // Waveform predictor: tracks the frame state tick by tick and queues
   // the LED / busy / done sample that each accepted tick must produce.
   // ----------------------------------------------------------------------
   class led_wave_model;
      cfg_type          cfg;
      phase_type        ph;
      logic [31:0]      word;
      logic [5:0]       bits_left;
      logic [17:0]      dur;
      logic [7:0]       cycles_left;
      logic             level;
      led_sample_type   expected_ticks[$];
      int               ticks_seen;
      int               frames_started;
      int               frames_done;
      int               starts_ignored;
      int               failures;
      int               shown;

      function new();
         cfg.carrier_half = CARRIER_HALF_RST;
         cfg.hdr_mark     = HDR_MARK_RST;
         cfg.hdr_space    = HDR_SPACE_RST;
         cfg.bit_mark     = BIT_MARK_RST;
         cfg.one_space    = ONE_SPACE_RST;
         cfg.zero_space   = ZERO_SPACE_RST;
         cfg.gap          = GAP_RST;
         ph = PH_IDLE;
         word = '0;
         bits_left = '0;
         dur = '0;
         cycles_left = '0;
         level = 1'b0;
         ticks_seen = 0;
         frames_started = 0;
         frames_done = 0;
         starts_ignored = 0;
         failures = 0;
         shown = 0;
      endfunction

      function void set_reg(input reg_idx_type idx, input logic [31:0] v);
         case (idx)
            REG_CARRIER_HALF: cfg.carrier_half = v[7:0];
            REG_HDR_MARK:     cfg.hdr_mark = v[7:0];
            REG_HDR_SPACE:    cfg.hdr_space = v[15:0];
            REG_BIT_MARK:     cfg.bit_mark = v[7:0];
            REG_ONE_SPACE:    cfg.one_space = v[15:0];
            REG_ZERO_SPACE:   cfg.zero_space = v[15:0];
            REG_GAP:          cfg.gap = v[17:0];
            default: ;
         endcase
      endfunction

      // zero lengths count as one
      function logic [17:0] half_len();
         return (cfg.carrier_half == 8'd0) ? 18'd1 : 18'(cfg.carrier_half);
      endfunction

      function void open_mark(input logic [7:0] cycles);
         cycles_left = (cycles == 8'd0) ? 8'd1 : cycles;
         level = 1'b1;
         dur = half_len();
      endfunction

      function void open_space(input logic [15:0] ticks);
         dur = (ticks == 16'd0) ? 18'd1 : 18'(ticks);
      endfunction

      function int pending();
         return expected_ticks.size();
      endfunction

      // one accepted tick transaction
      function void take_tick(input logic start, input logic [31:0] word_in);
         led_sample_type exp_s;
         logic mark_over;
         exp_s = '0;
         mark_over = 1'b0;
         ticks_seen++;
         if (ph == PH_IDLE && start) begin
            word = word_in;
            bits_left = 6'(FRAME_BYTES * 8 - 1);
            ph = PH_HDR_MARK;
            open_mark(cfg.hdr_mark);
            frames_started++;
         end else if (start) begin
            starts_ignored++;
         end
         if (ph != PH_IDLE) begin
            exp_s.busy = 1'b1;
            if (ph == PH_HDR_MARK || ph == PH_BIT_MARK || ph == PH_CLOSE_MARK) begin
               exp_s.led = level;
               dur = dur - 18'd1;
               if (dur == 18'd0) begin
                  if (level) begin
                     level = 1'b0;
                     dur = half_len();
                  end else begin
                     cycles_left = cycles_left - 8'd1;
                     if (cycles_left == 8'd0) begin
                        mark_over = 1'b1;
                     end else begin
                        level = 1'b1;
                        dur = half_len();
                     end
                  end
               end
               if (mark_over) begin
                  if (ph == PH_HDR_MARK) begin
                     ph = PH_HDR_SPACE;
                     open_space(cfg.hdr_space);
                  end else if (ph == PH_BIT_MARK) begin
                     ph = PH_BIT_SPACE;
                     open_space(word[31] ? cfg.one_space : cfg.zero_space);
                  end else if (cfg.gap == 18'd0) begin
                     // no gap: frame ends on the closing mark
                     exp_s.done = 1'b1;
                     ph = PH_IDLE;
                  end else begin
                     ph = PH_GAP;
                     dur = cfg.gap;
                  end
               end
            end else begin
               dur = dur - 18'd1;
               if (dur == 18'd0) begin
                  if (ph == PH_HDR_SPACE) begin
                     ph = PH_BIT_MARK;
                     open_mark(cfg.bit_mark);
                  end else if (ph == PH_BIT_SPACE) begin
                     if (bits_left == 6'd0) begin
                        ph = PH_CLOSE_MARK;
                     end else begin
                        word = word << 1;
                        bits_left = bits_left - 6'd1;
                        ph = PH_BIT_MARK;
                     end
                     open_mark(cfg.bit_mark);
                  end else begin
                     exp_s.done = 1'b1;
                     ph = PH_IDLE;
                  end
               end
            end
         end
         if (exp_s.done) frames_done++;
         expected_ticks.push_back(exp_s);
      endfunction

      // one accepted result transaction
      function void check_tick(input logic led, input logic busy, input logic done);
         led_sample_type exp_s;
         if (expected_ticks.size() == 0) begin
            failures++;
            if (shown < 10) begin
               shown++;
               $display("ERROR: result led=%b busy=%b done=%b with nothing expected",
                        led, busy, done);
            end
            return;
         end
         exp_s = expected_ticks.pop_front();
         if (led !== exp_s.led || busy !== exp_s.busy || done !== exp_s.done) begin
            failures++;
            if (shown < 10) begin
               shown++;
               $display("ERROR: led/busy/done expected %b/%b/%b, got %b/%b/%b",
                        exp_s.led, exp_s.busy, exp_s.done, led, busy, done);
            end
         end
      endfunction

      function void finish_check();
         if (expected_ticks.size() != 0) begin
            failures++;
            $display("ERROR: %0d expected results never arrived", expected_ticks.size());
         end
      endfunction
   endclass

   // ----------------------------------------------------------------------
   // Clock, reset, channels and CSR port
   // ----------------------------------------------------------------------
   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   ihfm_req_if req_if();
   ihfm_rsp_if rsp_if();

   led_wave_model wave;
   int results_seen;
   int settings_used;
   int send_calm;
   int recv_calm;
   bit long_hold_done;

   ir_helicopter_frame_modulator #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req(req_if),
      .rsp(rsp_if),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #4 clock = ~clock;

   // Gap length for either side: mostly none, sometimes short, rarely long.
   // A calm counter gives stretches with no gaps at all.
   function automatic int idle_len(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 199);
      if (r < 2) begin
         calm = $urandom_range(30, 120);
         return 0;
      end
      if (r < 140) return 0;
      if (r < 190) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic cfg_type make_cfg(input int ch, input int hm, input int hs,
                                        input int bm, input int one_s, input int zero_s,
                                        input int gp);
      cfg_type c;
      c.carrier_half = 8'(ch);
      c.hdr_mark     = 8'(hm);
      c.hdr_space    = 16'(hs);
      c.bit_mark     = 8'(bm);
      c.one_space    = 16'(one_s);
      c.zero_space   = 16'(zero_s);
      c.gap          = 18'(gp);
      return c;
   endfunction

   // Random tick: start request with the given odds, bytes biased to extremes
   function automatic tick_type rand_tick(input int start_pct);
      tick_type t;
      t.start = ($urandom_range(0, 99) < start_pct);
      for (int i = 0; i < 4; i++) begin
         case ($urandom_range(0, 9))
            0: t.word[8*i +: 8] = 8'h00;
            1: t.word[8*i +: 8] = 8'hFF;
            default: t.word[8*i +: 8] = 8'($urandom);
         endcase
      end
      return t;
   endfunction

   // APB write: setup cycle, then access cycle; register lands at the access edge
   task automatic csr_write(input reg_idx_type idx, input logic [31:0] val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      wave.set_reg(idx, val);
   endtask

   task automatic write_cfg(input cfg_type c);
      csr_write(REG_CARRIER_HALF, 32'(c.carrier_half));
      csr_write(REG_HDR_MARK, 32'(c.hdr_mark));
      csr_write(REG_HDR_SPACE, 32'(c.hdr_space));
      csr_write(REG_BIT_MARK, 32'(c.bit_mark));
      csr_write(REG_ONE_SPACE, 32'(c.one_space));
      csr_write(REG_ZERO_SPACE, 32'(c.zero_space));
      csr_write(REG_GAP, 32'(c.gap));
      settings_used++;
   endtask

   // Offer one tick transaction and hold it until accepted. valid stays high
   // into the next call when no gap follows, so it is never dropped and raised
   // in the same step.
   task automatic send_tick(input tick_type t);
      int gap;
      req_if.valid <= 1'b1;
      req_if.start_req <= t.start;
      req_if.yaw_byte <= t.word[31:24];
      req_if.pitch_byte <= t.word[23:16];
      req_if.throttle_byte <= t.word[15:8];
      req_if.trim_byte <= t.word[7:0];
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      wave.take_tick(t.start, t.word);
      gap = idle_len(send_calm);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drain: no input offered until every expected result is in, plus margin
   task automatic settle();
      req_if.valid <= 1'b0;
      while (wave.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input cfg_type c, input int n_ticks, input int start_pct);
      write_cfg(c);
      repeat (n_ticks) send_tick(rand_tick(start_pct));
      settle();
   endtask

   // ----------------------------------------------------------------------
   // Result side: checks each accepted result, stalls at random, and once
   // holds off for a long stretch so the block backs up into its input.
   // ----------------------------------------------------------------------
   initial begin
      int stall_left;
      stall_left = 0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) begin
            wave.check_tick(rsp_if.led_on, rsp_if.busy_res, rsp_if.frame_done);
            results_seen++;
         end
         if (stall_left > 0) begin
            stall_left--;
         end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            stall_left = HOLD_CYCLES;
         end else begin
            stall_left = idle_len(recv_calm);
         end
         rsp_if.ready <= (stall_left == 0);
      end
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("ERROR: timeout, %0d results seen", results_seen);
      $display("Verification failed");
      $finish;
   end

   // ----------------------------------------------------------------------
   // Main sequence
   // ----------------------------------------------------------------------
   initial begin
      tick_type t;
      clock = 1'b0;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_if.valid = 1'b0;
      req_if.start_req = 1'b0;
      req_if.yaw_byte = '0;
      req_if.pitch_byte = '0;
      req_if.throttle_byte = '0;
      req_if.trim_byte = '0;
      rsp_if.ready = 1'b0;
      results_seen = 0;
      settings_used = 0;
      send_calm = 0;
      recv_calm = 0;
      long_hold_done = 1'b0;
      wave = new();

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed at reset timing: idle ticks with no start, a start with
      // extreme bytes (LED high on the start tick), then starts while busy
      // that must be dropped, across the first carrier high/low edge.
      t.start = 1'b0;
      t.word = 32'hFFFF_FFFF;
      send_tick(t);
      t.word = 32'h0000_0000;
      send_tick(t);
      t.start = 1'b1;
      t.word = 32'hFF00_AA55;
      send_tick(t);
      for (int i = 0; i < 22; i++) begin
         t.start = (i % 3 == 0);
         t.word = (i % 2 == 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
         send_tick(t);
      end
      settle();

      // All zeros: every length acts as one, zero gap ends on the closing mark
      run_phase(make_cfg(0, 0, 0, 0, 0, 0, 0), 260, 50);
      // Lowest legal values with a one-tick gap
      run_phase(make_cfg(1, 1, 1, 1, 1, 1, 1), 200, 40);
      // Short random timings, busy or sparse start traffic
      repeat (2) begin
         run_phase(make_cfg($urandom_range(0, 2), $urandom_range(1, 3),
                            $urandom_range(1, 8), $urandom_range(0, 1),
                            $urandom_range(1, 10), $urandom_range(0, 6),
                            $urandom_range(0, 24)),
                   160, $urandom_range(5, 60));
      end
      // Top of every register; lengths are sampled as new intervals begin
      run_phase(make_cfg(255, 255, 65535, 255, 65535, 65535, 262143), 50, 30);

      wave.finish_check();
      $display("Run covered %0d ticks over %0d timing settings plus reset defaults.",
               wave.ticks_seen, settings_used);
      $display("Frames started %0d, finished %0d; %0d starts dropped while busy.",
               wave.frames_started, wave.frames_done, wave.starts_ignored);
      if (wave.failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches in total", wave.failures);
         $display("Verification failed");
      end
      $finish;
   end

endmodule
